// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL modules.
// Both expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define LCFG_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define LCFG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: hw/rtl/lcfg_pkg.sv
`default_nettype none
package lcfg_pkg;

  localparam int TIME_W     = 64;
  localparam int COLOR_W    = 8;
  localparam int NUM_CH     = 4;
  localparam int CH_W       = 2;
  localparam int FADE_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int TICKS_PER_SECOND_DEF = 1000000;

  localparam int BLEND_FRACTION_BITS = 16;
  localparam int GAMMA_TABLE_BITS    = 8;
  localparam int GT_SIZE             = 1 << GAMMA_TABLE_BITS;
  localparam int GT_LAST             = GT_SIZE - 1;
  localparam int BLEND_W             = BLEND_FRACTION_BITS + 1;
  localparam logic [BLEND_W-1:0] BLEND_MAX = BLEND_W'(1) << BLEND_FRACTION_BITS;

  // Wide enough for m^11 * GT_LAST^5 with m up to 2^(F+1).
  localparam int BN_W = 11 * (BLEND_FRACTION_BITS + 1) + 5 * GAMMA_TABLE_BITS + 2;

  localparam int CNT_W = $clog2((GAMMA_TABLE_BITS > NUM_CH) ? GAMMA_TABLE_BITS : NUM_CH);

  typedef logic [COLOR_W-1:0] color_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TGT_RED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TGT_GREEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TGT_BLUE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TGT_WHITE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_SEC  = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ELAP,
    S_PREP,
    S_DIV,
    S_LUT,
    S_MIX,
    S_DONE
  } state_t;

  typedef struct packed {
    logic            load;      // input transaction taken this cycle
    logic            elap;      // form elapsed time
    logic            prep;      // set up divider or force full progress
    logic            div_step;  // one quotient bit
    logic            lut;       // look up blend
    logic            mix;       // blend one channel
    logic [CH_W-1:0] ch;
    logic            out_load;  // move color into the output register
  } ctl_cmd_t;

  typedef struct packed {
    logic full;  // progress is clamped to the last table entry
  } dp_sts_t;

  // Entry k: round_half_up(2^F * (k / GT_LAST)^(5/11)), exact integer search.
  function automatic logic [BLEND_W-1:0] gamma_entry(input int unsigned k);
    logic [BN_W-1:0]              rhs;
    logic [BN_W-1:0]              lhs;
    logic [BLEND_FRACTION_BITS+1:0] lo;
    logic [BLEND_FRACTION_BITS+1:0] hi;
    logic [BLEND_FRACTION_BITS+1:0] mid;
    rhs = BN_W'(1);
    for (int i = 0; i < 5; i++) begin
      rhs = rhs * BN_W'(k);
    end
    rhs = rhs << (11 * (BLEND_FRACTION_BITS + 1));
    lo  = '0;
    hi  = (BLEND_FRACTION_BITS + 2)'(1) << (BLEND_FRACTION_BITS + 1);
    for (int it = 0; it < BLEND_FRACTION_BITS + 2; it++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 1'b1) >> 1);
        lhs = BN_W'(1);
        for (int i = 0; i < 11; i++) begin
          lhs = lhs * BN_W'(mid);
        end
        for (int i = 0; i < 5; i++) begin
          lhs = lhs * BN_W'(GT_LAST);
        end
        if (lhs <= rhs) begin
          lo = mid;
        end else begin
          hi = mid - 1'b1;
        end
      end
    end
    return BLEND_W'((lo + 1'b1) >> 1);
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/lcfg_if.sv
`default_nettype none
interface lcfg_in_if;
  logic                                valid;
  logic                                ready;
  logic [lcfg_pkg::TIME_W-1:0]         now_micros;
  logic                                strip_nonempty;
  logic [lcfg_pkg::COLOR_W-1:0]        sample_red;
  logic [lcfg_pkg::COLOR_W-1:0]        sample_green;
  logic [lcfg_pkg::COLOR_W-1:0]        sample_blue;
  logic [lcfg_pkg::COLOR_W-1:0]        sample_white;

  modport source (output valid, now_micros, strip_nonempty, sample_red, sample_green,
                  sample_blue, sample_white, input ready);
  modport sink   (input valid, now_micros, strip_nonempty, sample_red, sample_green,
                  sample_blue, sample_white, output ready);
endinterface

interface lcfg_out_if;
  logic                         valid;
  logic                         ready;
  logic [lcfg_pkg::COLOR_W-1:0] out_red;
  logic [lcfg_pkg::COLOR_W-1:0] out_green;
  logic [lcfg_pkg::COLOR_W-1:0] out_blue;
  logic [lcfg_pkg::COLOR_W-1:0] out_white;

  modport source (output valid, out_red, out_green, out_blue, out_white, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_white, output ready);
endinterface

interface lcfg_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lcfg_pkg::CFG_IDX_W-1:0]  index;
  logic [lcfg_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/lcfg_ctrl.sv
`default_nettype none
`include "assert_macros.svh"
module lcfg_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire lcfg_pkg::dp_sts_t  sts,
  output lcfg_pkg::ctl_cmd_t      cmd
);
  import lcfg_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_ELAP;
      end
      S_ELAP: state_nxt = S_PREP;
      S_PREP: begin
        cnt_nxt   = '0;
        state_nxt = sts.full ? S_LUT : S_DIV;
      end
      S_DIV: begin
        if (cnt_r == CNT_W'(GAMMA_TABLE_BITS - 1)) begin
          state_nxt = S_LUT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_LUT: begin
        cnt_nxt   = '0;
        state_nxt = S_MIX;
      end
      S_MIX: begin
        if (cnt_r == CNT_W'(NUM_CH - 1)) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd          = '0;
    cmd.ch       = cnt_r[CH_W-1:0];
    cmd.load     = (state_r == S_IDLE) && in_valid;
    cmd.elap     = (state_r == S_ELAP);
    cmd.prep     = (state_r == S_PREP);
    cmd.div_step = (state_r == S_DIV);
    cmd.lut      = (state_r == S_LUT);
    cmd.mix      = (state_r == S_MIX);
    cmd.out_load = (state_r == S_DONE) && out_free;
    out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  `LCFG_ASSERT_NEXT(a_accept_starts_work, in_valid && in_ready, state_r == S_ELAP)
  `LCFG_ASSERT_NEXT(a_result_posted, cmd.out_load, out_valid_r && state_r == S_IDLE)
  `LCFG_ASSERT_SAME(a_div_count_bound, state_r == S_DIV,
                    cnt_r <= CNT_W'(GAMMA_TABLE_BITS - 1))

endmodule
`default_nettype wire

// File: hw/rtl/lcfg_dp.sv
`default_nettype none
`include "assert_macros.svh"
module lcfg_dp #(
  parameter int TICKS_PER_SECOND = lcfg_pkg::TICKS_PER_SECOND_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire lcfg_pkg::ctl_cmd_t               cmd,
  output lcfg_pkg::dp_sts_t                     sts,
  input  wire logic [lcfg_pkg::TIME_W-1:0]      now_micros,
  input  wire logic                             strip_nonempty,
  input  wire lcfg_pkg::color_t                 sample [lcfg_pkg::NUM_CH],
  input  wire logic                             cfg_we,
  input  wire logic [lcfg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lcfg_pkg::CFG_DATA_W-1:0]  cfg_data,
  output lcfg_pkg::color_t                      out_col [lcfg_pkg::NUM_CH]
);
  import lcfg_pkg::*;

  localparam int DUR_W = FADE_W + $clog2(TICKS_PER_SECOND + 1);
  localparam int NUM_W = DUR_W + GAMMA_TABLE_BITS + 1;
  localparam int MIX_W = BLEND_FRACTION_BITS + 11;
  localparam int VAL_W = MIX_W - 1 - BLEND_FRACTION_BITS;

  // Constant gamma table
  logic [BLEND_W-1:0] gamma_lut [GT_SIZE];
  for (genvar k = 0; k < GT_SIZE; k++) begin : g_lut
    localparam logic [BLEND_W-1:0] ENTRY = gamma_entry(k);
    assign gamma_lut[k] = ENTRY;
  end

  color_t                    tgt_r [NUM_CH];
  logic [FADE_W-1:0]         fade_sec_r;
  logic                      started_r, started_nxt;
  logic                      restart_r, restart_nxt;
  color_t                    start_col_r [NUM_CH];
  color_t                    last_col_r [NUM_CH];
  color_t                    out_col_r [NUM_CH];
  logic [TIME_W-1:0]         seg_start_r;
  logic [TIME_W-1:0]         now_r;
  logic [DUR_W-1:0]          dur_r;
  logic [TIME_W-1:0]         elapsed_r;
  logic                      wrap_r;
  logic [NUM_W-1:0]          rem_r;
  logic [NUM_W-1:0]          dsr_r;
  logic [GAMMA_TABLE_BITS-1:0] idx_r;
  logic [BLEND_W-1:0]        blend_r;

  logic                      tgt_wr;
  logic                      latch;
  logic                      div_ge;
  logic signed [8:0]         mix_diff;
  logic signed [MIX_W-1:0]   mix_prod;
  logic signed [MIX_W-1:0]   mix_base;
  logic signed [MIX_W-1:0]   mix_num;
  logic [MIX_W-1:0]          mix_rnd;
  logic [VAL_W-1:0]          mix_val;
  color_t                    mix_res;

  assign tgt_wr = cfg_we && (cfg_index inside {REG_TGT_RED, REG_TGT_GREEN,
                                               REG_TGT_BLUE, REG_TGT_WHITE});
  assign latch  = !started_r || restart_r;

  assign sts.full = (dur_r == '0) || wrap_r || (elapsed_r >= TIME_W'(dur_r));

  assign div_ge = (rem_r >= dsr_r);

  // Channel blend: start + (target - start) * blend, round half up, clamp
  always_comb begin
    mix_diff = $signed({1'b0, tgt_r[cmd.ch]}) - $signed({1'b0, start_col_r[cmd.ch]});
    mix_prod = MIX_W'(mix_diff) * $signed(MIX_W'(blend_r));
    mix_base = $signed({3'b000, start_col_r[cmd.ch], {BLEND_FRACTION_BITS{1'b0}}});
    mix_num  = mix_base + mix_prod;
    mix_rnd  = $unsigned(mix_num) + (MIX_W'(1) << (BLEND_FRACTION_BITS - 1));
    mix_val  = mix_rnd[MIX_W-2:BLEND_FRACTION_BITS];
    if (mix_num[MIX_W-1]) begin
      mix_res = '0;
    end else if (mix_val > VAL_W'(255)) begin
      mix_res = 8'hFF;
    end else begin
      mix_res = mix_val[COLOR_W-1:0];
    end
  end

  always_comb begin
    started_nxt = started_r;
    restart_nxt = restart_r;
    if (cmd.load) begin
      started_nxt = 1'b1;
      restart_nxt = 1'b0;
    end
    if (tgt_wr) restart_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r  <= 1'b0;
      restart_r  <= 1'b0;
      fade_sec_r <= '0;
      for (int c = 0; c < NUM_CH; c++) begin
        tgt_r[c]      <= '0;
        last_col_r[c] <= '0;
      end
    end else begin
      started_r <= started_nxt;
      restart_r <= restart_nxt;
      if (tgt_wr) tgt_r[cfg_index[CH_W-1:0]] <= cfg_data[COLOR_W-1:0];
      if (cfg_we && cfg_index == REG_FADE_SEC) fade_sec_r <= cfg_data[FADE_W-1:0];
      if (cmd.mix) last_col_r[cmd.ch] <= mix_res;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r <= now_micros;
      dur_r <= DUR_W'(fade_sec_r) * DUR_W'(TICKS_PER_SECOND);
      if (latch) begin
        seg_start_r <= now_micros;
        for (int c = 0; c < NUM_CH; c++) begin
          start_col_r[c] <= strip_nonempty ? sample[c] : last_col_r[c];
        end
      end
    end
    if (cmd.elap) begin
      elapsed_r <= now_r - seg_start_r;
      wrap_r    <= (now_r < seg_start_r);
    end
    if (cmd.prep) begin
      // numerator 2*GT_LAST*elapsed + dur over divisor 2*dur gives the rounded index
      rem_r <= NUM_W'(elapsed_r[DUR_W-1:0]) * NUM_W'(2 * GT_LAST) + NUM_W'(dur_r);
      dsr_r <= NUM_W'({dur_r, 1'b0}) << (GAMMA_TABLE_BITS - 1);
      idx_r <= sts.full ? GAMMA_TABLE_BITS'(GT_LAST) : '0;
    end
    if (cmd.div_step) begin
      if (div_ge) rem_r <= rem_r - dsr_r;
      dsr_r <= dsr_r >> 1;
      idx_r <= {idx_r[GAMMA_TABLE_BITS-2:0], div_ge};
    end
    if (cmd.lut) blend_r <= gamma_lut[idx_r];
    if (cmd.out_load) begin
      for (int c = 0; c < NUM_CH; c++) begin
        out_col_r[c] <= last_col_r[c];
      end
    end
  end

  assign out_col = out_col_r;

  `LCFG_ASSERT_NEXT(a_latch_clears_restart, cmd.load && !tgt_wr, started_r && !restart_r)
  `LCFG_ASSERT_NEXT(a_rem_never_grows, cmd.div_step, rem_r <= $past(rem_r))
  `LCFG_ASSERT_NEXT(a_blend_bound, cmd.lut, blend_r <= BLEND_MAX)

endmodule
`default_nettype wire

// File: hw/rtl/led_color_fade_gamma_core.sv
`default_nettype none
// Channel   Dir  Handshake     Payload
// in_chan   in   valid/ready   now_micros, strip_nonempty, sample_red/green/blue/white
// out_chan  out  valid/ready   out_red, out_green, out_blue, out_white
// cfg_chan  in   valid/ready   index (0..3 targets, 4 fade_seconds), data
//
// When progress is full (zero duration, wrapped time or fade done) a tick skips
// the 8-step shift-subtract divider that forms the table index; each tick then
// blends the channels in turn through the single shared channel multiplier.
// The output register holds a color while the next tick is accepted and worked on.
// Reset is synchronous; all targets, fade duration and last color clear to zero.
// cfg_chan is always ready.
module led_color_fade_gamma_core #(
  parameter int TICKS_PER_SECOND = lcfg_pkg::TICKS_PER_SECOND_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lcfg_in_if.sink     in_chan,
  lcfg_out_if.source  out_chan,
  lcfg_cfg_if.sink    cfg_chan
);
  import lcfg_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;
  logic     in_rdy;
  logic     out_vld;
  color_t   sample [NUM_CH];
  color_t   out_col [NUM_CH];

  assign sample[0] = in_chan.sample_red;
  assign sample[1] = in_chan.sample_green;
  assign sample[2] = in_chan.sample_blue;
  assign sample[3] = in_chan.sample_white;

  assign in_chan.ready    = in_rdy;
  assign out_chan.valid   = out_vld;
  assign out_chan.out_red   = out_col[0];
  assign out_chan.out_green = out_col[1];
  assign out_chan.out_blue  = out_col[2];
  assign out_chan.out_white = out_col[3];
  assign cfg_chan.ready   = 1'b1;

  lcfg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_rdy),
    .out_valid (out_vld),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lcfg_dp #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .now_micros     (in_chan.now_micros),
    .strip_nonempty (in_chan.strip_nonempty),
    .sample         (sample),
    .cfg_we         (cfg_chan.valid),
    .cfg_index      (cfg_chan.index),
    .cfg_data       (cfg_chan.data),
    .out_col        (out_col)
  );

endmodule
`default_nettype wire

// File: dv/tb.sv
`default_nettype none
module tb;
  import lcfg_pkg::*;

  typedef logic [NUM_CH-1:0][COLOR_W-1:0] rgbw_t;  // [0] red .. [3] white

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [TIME_W-1:0]    USEC         = TIME_W'(TICKS_PER_SECOND_DEF);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_FADE_SEC + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

  logic clk;
  logic rst_n;

  lcfg_in_if  in_if ();
  lcfg_out_if out_if ();
  lcfg_cfg_if cfg_if ();

  led_color_fade_gamma_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // fade state mirrored on the testbench side
  logic [BLEND_W-1:0] gamma_lut [GT_SIZE];
  rgbw_t              fd_target;
  rgbw_t              fd_start_color;
  rgbw_t              fd_last_color;
  logic [FADE_W-1:0]  fd_seconds;
  logic [TIME_W-1:0]  fd_seg_start;
  bit                 fd_started;
  bit                 fd_restart;

  rgbw_t       pending_colors [$];
  int unsigned mismatches = 0;
  int unsigned ticks_sent = 0;
  int          hold_req   = 0;
  bit          steady     = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Largest root with (root / 2^(F+1))^11 <= (k / GT_LAST)^5, built bit by bit.
  function automatic logic [BLEND_W-1:0] gamma_root(int unsigned k);
    logic [255:0]     bound;
    logic [255:0]     power;
    logic [BLEND_W:0] root;
    logic [BLEND_W:0] trial;
    bound = 256'd1;
    for (int i = 0; i < 5; i++) bound = bound * 256'(k);
    bound = bound << (11 * BLEND_W);
    root = '0;
    for (int b = BLEND_W; b >= 0; b--) begin
      trial = root | ((BLEND_W + 1)'(1) << b);
      power = 256'd1;
      for (int i = 0; i < 11; i++) power = power * 256'(trial);
      for (int i = 0; i < 5; i++) power = power * 256'(GT_LAST);
      if ((trial <= ((BLEND_W + 1)'(1) << BLEND_W)) && (power <= bound)) root = trial;
    end
    return BLEND_W'((root + 1'b1) >> 1);
  endfunction

  function automatic color_t blend_channel(color_t src, color_t dst, logic [BLEND_W-1:0] w);
    longint s;
    longint d;
    longint wt;
    longint acc;
    s   = src;
    d   = dst;
    wt  = w;
    acc = (s <<< BLEND_FRACTION_BITS) + (d - s) * wt;
    if (acc < 0) acc = 0;
    acc = (acc + (longint'(1) <<< (BLEND_FRACTION_BITS - 1))) >>> BLEND_FRACTION_BITS;
    return (acc > 255) ? 8'hFF : color_t'(acc);
  endfunction

  function automatic rgbw_t fade_color(logic [TIME_W-1:0] now, bit nonempty, rgbw_t sample);
    logic [TIME_W-1:0] span;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] step;
    rgbw_t             color;
    step = GT_LAST;
    // latch a new segment on the first tick after reset or a target write
    if (!fd_started || fd_restart) begin
      fd_start_color = nonempty ? sample : fd_last_color;
      fd_seg_start   = now;
      fd_started     = 1'b1;
      fd_restart     = 1'b0;
    end
    span = TIME_W'(fd_seconds) * USEC;
    if (span != 0 && now >= fd_seg_start) begin
      elapsed = now - fd_seg_start;
      if (elapsed < span) step = (elapsed * TIME_W'(2 * GT_LAST) + span) / (span << 1);
    end
    for (int c = 0; c < NUM_CH; c++) begin
      color[c] = blend_channel(fd_start_color[c], fd_target[c],
                               gamma_lut[step[GAMMA_TABLE_BITS-1:0]]);
    end
    fd_last_color = color;
    return color;
  endfunction

  function automatic void check_channel(string name, color_t want, color_t got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_tick(logic [TIME_W-1:0] now, bit nonempty, rgbw_t sample);
    if (!steady && $urandom_range(99) < 6) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.now_micros     <= now;
    in_if.strip_nonempty <= nonempty;
    in_if.sample_red     <= sample[0];
    in_if.sample_green   <= sample[1];
    in_if.sample_blue    <= sample[2];
    in_if.sample_white   <= sample[3];
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_colors.push_back(fade_color(now, nonempty, sample));
    ticks_sent++;
  endtask

  // hold the sender until every color has come out
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_colors.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    if (idx <= REG_TGT_WHITE) begin
      fd_target[idx[CH_W-1:0]] = data[COLOR_W-1:0];
      fd_restart               = 1'b1;
    end else if (idx == REG_FADE_SEC) begin
      fd_seconds = data[FADE_W-1:0];
    end
  endtask

  task automatic test_after_reset();
    send_tick(64'd1000, 1'b0, 32'hFFFF_FFFF);
    send_tick(64'd2000, 1'b1, 32'h8040_2010);
  endtask

  task automatic test_directed_fades();
    logic [TIME_W-1:0] base;
    logic [TIME_W-1:0] longest;
    base    = 64'h0123_4567_89AB_CDEF;
    longest = TIME_W'(16'hFFFF) * USEC;
    // zero duration jumps; upper data bits drop
    write_reg(REG_FADE_SEC, 16'd0);
    write_reg(REG_TGT_RED, 16'hAB12);
    write_reg(REG_TGT_GREEN, 16'h00FF);
    write_reg(REG_TGT_BLUE, 16'h0000);
    write_reg(REG_TGT_WHITE, 16'hFF80);
    send_tick(64'd0, 1'b1, 32'h1111_1111);
    write_reg(REG_FADE_SEC, 16'd1);
    write_reg(REG_TGT_RED, 16'h00FF);
    send_tick(base, 1'b1, 32'hAA55_FF00);
    send_tick(base + 64'd1, 1'b1, 32'h0);
    send_tick(base + 64'd500_000, 1'b0, 32'hFFFF_FFFF);
    send_tick(base + 64'd999_999, 1'b1, 32'h0);
    send_tick(base + USEC, 1'b1, 32'h0);
    send_tick(base - 64'd1, 1'b1, 32'h0);
    send_tick(base + 4 * USEC, 1'b1, 32'h0);
    // duration change alone keeps the running segment
    write_reg(REG_FADE_SEC, 16'd3);
    send_tick(base + 64'd1_500_000, 1'b1, 32'h0);
    for (int i = REG_SPARE_LO; i <= REG_SPARE_HI; i++) write_reg(CFG_IDX_W'(i), '1);
    send_tick(base + 64'd2_000_000, 1'b1, 32'h1234_5678);
    // empty strip restarts from the last color
    write_reg(REG_TGT_GREEN, 16'h0000);
    send_tick(64'd0, 1'b0, 32'hDEAD_BEEF);
    send_tick(USEC, 1'b0, 32'h0);
    write_reg(REG_FADE_SEC, 16'hFFFF);
    write_reg(REG_TGT_WHITE, 16'h00FF);
    send_tick(64'd0, 1'b1, 32'h0000_0000);
    send_tick(longest >> 1, 1'b1, 32'hFFFF_FFFF);
    send_tick(longest - 64'd1, 1'b1, 32'h0);
    send_tick('1, 1'b1, 32'h0);
    // start at the top of the time range, then wrap
    write_reg(REG_TGT_BLUE, 16'h00FF);
    send_tick('1, 1'b1, 32'h0);
    send_tick(64'd0, 1'b1, 32'h0);
    send_tick(64'd5, 1'b1, 32'hFFFF_FFFF);
  endtask

  task automatic fade_segment(int unsigned count);
    int unsigned       pick;
    logic [TIME_W-1:0] base;
    logic [TIME_W-1:0] span;
    logic [TIME_W-1:0] stride;
    logic [TIME_W-1:0] now;
    pick = $urandom_range(99);
    if (pick < 15) write_reg(REG_FADE_SEC, '0);
    else if (pick < 80) write_reg(REG_FADE_SEC, CFG_DATA_W'($urandom_range(4, 1)));
    else if (pick < 90) write_reg(REG_FADE_SEC, CFG_DATA_W'($urandom));
    else if (pick < 95) write_reg(REG_FADE_SEC, '1);
    // targets sit at consecutive indexes
    for (int c = 0; c < NUM_CH; c++) begin
      if ($urandom_range(99) < 60) write_reg(CFG_IDX_W'(REG_TGT_RED + c), CFG_DATA_W'($urandom));
    end
    if ($urandom_range(99) < 5) begin
      write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)), CFG_DATA_W'($urandom));
    end
    span   = TIME_W'(fd_seconds) * USEC;
    stride = (span == 0) ? 64'd2000 : (span + (span >> 2)) * 2 / count + 1;
    base   = {$urandom, $urandom};
    now    = base;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (i != 0 && pick < 4) begin
        send_tick({$urandom, $urandom}, $urandom_range(3) != 0, rgbw_t'($urandom));
      end else if (i != 0 && pick < 8) begin
        send_tick(base - $urandom_range(1000, 1), $urandom_range(3) != 0, rgbw_t'($urandom));
      end else begin
        send_tick(now, $urandom_range(3) != 0, rgbw_t'($urandom));
        now = now + {$urandom, $urandom} % stride;
      end
      if (pick == 99 && !steady) drain();
    end
  endtask

  task automatic test_random_fades();
    int unsigned seg;
    seg = 0;
    while (ticks_sent < 1900) begin
      steady = (seg == 10);
      fade_segment((seg == 10) ? 200 : $urandom_range(40, 5));
      seg++;
    end
    steady = 1'b0;
  endtask

  // receiver holds off while ticks keep coming, so the block backs up
  task automatic test_output_stall();
    write_reg(REG_FADE_SEC, 16'd2);
    write_reg(REG_TGT_RED, 16'h00C0);
    hold_req = HOLD_CYCLES;
    for (int i = 0; i < 60; i++) begin
      send_tick(64'd1000 + TIME_W'(i) * 64'd50_000, 1'b1, rgbw_t'($urandom));
    end
    drain();
  endtask

  initial begin : result_sink
    int hold;
    hold = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold     = hold_req;
        hold_req = 0;
      end
      if (hold != 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= steady || ($urandom_range(99) >= 6);
      end
    end
  end

  always @(posedge clk) begin : color_check
    rgbw_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_colors.size() == 0) begin
        $error("color arrived with no tick waiting: %h",
               {out_if.out_white, out_if.out_blue, out_if.out_green, out_if.out_red});
        mismatches++;
      end else begin
        want = pending_colors.pop_front();
        check_channel("out_red", want[0], out_if.out_red);
        check_channel("out_green", want[1], out_if.out_green);
        check_channel("out_blue", want[2], out_if.out_blue);
        check_channel("out_white", want[3], out_if.out_white);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_n                <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.now_micros     <= '0;
    in_if.strip_nonempty <= 1'b0;
    in_if.sample_red     <= '0;
    in_if.sample_green   <= '0;
    in_if.sample_blue    <= '0;
    in_if.sample_white   <= '0;
    cfg_if.valid         <= 1'b0;
    cfg_if.index         <= '0;
    cfg_if.data          <= '0;
    for (int k = 0; k < GT_SIZE; k++) gamma_lut[k] = gamma_root(k);
    fd_target      = '0;
    fd_start_color = '0;
    fd_last_color  = '0;
    fd_seconds     = '0;
    fd_seg_start   = '0;
    fd_started     = 1'b0;
    fd_restart     = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_after_reset();
    test_directed_fades();
    test_random_fades();
    test_output_stall();
    drain();
    repeat (30) @(posedge clk);
    if (mismatches == 0 && pending_colors.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: led_color_fade_gamma_core.f
+incdir+hw/rtl
hw/rtl/lcfg_pkg.sv
hw/rtl/lcfg_if.sv
hw/rtl/lcfg_ctrl.sv
hw/rtl/lcfg_dp.sv
hw/rtl/led_color_fade_gamma_core.sv
dv/tb.sv
